@@ rtl/core/gdfw_pkg.sv @@
// Shared constants for the depth-first graph walk unit: sizes, field widths,
// request and status codes. No dependencies.
package gdfw_pkg;

    localparam int MAX_NODES  = 16;
    localparam int MAX_DEGREE = 8;

    localparam int REQ_W      = 2;
    localparam int NODE_W     = 4;
    localparam int VALUE_W    = 8;
    localparam int CFG_W      = 5;
    localparam int STATUS_W   = 2;
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 8;

    localparam logic [REQ_W-1:0] REQ_ADD   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WALK  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

endpackage

@@ rtl/core/gdfw_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module gdfw_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 16,
    parameter int P_AW    = (P_DEPTH > 1) ? $clog2(P_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [P_AW-1:0]    i_waddr,
    input  logic [P_WIDTH-1:0] i_wdata,
    input  logic               i_re,
    input  logic [P_AW-1:0]    i_raddr,
    output logic [P_WIDTH-1:0] o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // hold read data until the next read
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/graph_depth_first_walk_unit.sv @@
// Top level of the depth-first graph walk unit: request sequencer, result register.
// Depends on gdfw_pkg and gdfw_ram (adjacency, list length and walk stack stores).
//
// Usage
//   Slave stream: one transaction per request. tuser carries the request kind
//   (add edge, depth-first walk, contains-value query); tdata carries the nodes
//   and the search value. tready is high only while the sequencer is idle.
//   Master stream: each request yields one or more result transactions; tlast
//   marks the final one. Add edge and query give one result, a walk gives the
//   start node and every newly reached node in recursive depth-first order.
//   Configuration: i_cfg_we writes node_count (0 acts as 1, large values clamp).
// Sequencing
//   One request at a time. Add edge reads both list lengths, then appends to each
//   list; a node out of range or a full list ends it early. Query scans the lists
//   of nodes below node_count in order up to the first match. Walk reads entries
//   one at a time, popping the stack when a list is done. One read port per store.
// Reset
//   Synchronous, active low. Clears list lengths (through per-entry valid bits),
//   visited marks, stack depth and node_count (back to its maximum). The
//   adjacency and stack stores are not cleared; no clearing pass is needed.
// Back-pressure
//   A finished result sits in the output register while the next request is
//   taken. During a walk the sequencer holds on a newly found node until the
//   output register can take the previous one; no result is dropped.
module graph_depth_first_walk_unit #(
    parameter int P_MAX_NODES  = gdfw_pkg::MAX_NODES,
    parameter int P_MAX_DEGREE = gdfw_pkg::MAX_DEGREE
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration: node_count
    input  logic                             i_cfg_we,
    input  logic [gdfw_pkg::CFG_W-1:0]       i_cfg_wdata,
    // request stream
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // tdata fields from bit 0: first_node[3:0], second_node[7:4], search_value[15:8]
    input  logic [gdfw_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser fields from bit 0: req_type[1:0]
    input  logic [gdfw_pkg::REQ_W-1:0]       i_s_axis_tuser,
    // result stream
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // tdata fields from bit 0: node_id[3:0], found[4], status[6:5], zero pad[7]
    output logic [gdfw_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    output logic                             o_m_axis_tlast
);

    import gdfw_pkg::*;

    localparam int NIW = $clog2(P_MAX_NODES);
    localparam int LW  = $clog2(P_MAX_DEGREE + 1);
    localparam int AW  = $clog2(P_MAX_NODES * P_MAX_DEGREE);
    localparam int CW  = $clog2(P_MAX_NODES + 1);
    localparam int SW  = NIW + LW;

    typedef enum logic [13:0] {
        S_IDLE    = 14'b00000000000001,
        S_DECODE  = 14'b00000000000010,
        S_ADD_LB  = 14'b00000000000100,
        S_ADD_CHK = 14'b00000000001000,
        S_ADD_W2  = 14'b00000000010000,
        S_W_LEN   = 14'b00000000100000,
        S_W_STEP  = 14'b00000001000000,
        S_W_POP   = 14'b00000010000000,
        S_W_NB    = 14'b00000100000000,
        S_W_FIN   = 14'b00001000000000,
        S_Q_LENW  = 14'b00010000000000,
        S_Q_STEP  = 14'b00100000000000,
        S_Q_CMP   = 14'b01000000000000,
        S_RES     = 14'b10000000000000
    } t_state;

    // adjacency list entry address: node row plus position in the row
    function automatic logic [AW-1:0] f_adj_addr(input logic [NIW-1:0] node,
                                                 input logic [LW-1:0]  pos);
        return AW'(node) * AW'(P_MAX_DEGREE) + AW'(pos);
    endfunction

    t_state               r_state, n_state;
    logic [REQ_W-1:0]     r_req, n_req;
    logic [NODE_W-1:0]    r_first, n_first;
    logic [NODE_W-1:0]    r_second, n_second;
    logic [VALUE_W-1:0]   r_value, n_value;
    logic [CW-1:0]        r_node_count;
    logic [CW-1:0]        cfg_clamped;
    logic [LW-1:0]        r_la, n_la;
    logic [LW-1:0]        r_lb, n_lb;
    logic [NIW-1:0]       r_cur, n_cur;
    logic [LW-1:0]        r_pos, n_pos;
    logic [LW-1:0]        r_len, n_len;
    logic [CW-1:0]        r_sdepth, n_sdepth;
    logic [NIW-1:0]       r_pend, n_pend;
    logic [CW-1:0]        r_qi, n_qi;
    logic [NODE_W-1:0]    r_res_node, n_res_node;
    logic                 r_res_found, n_res_found;
    logic [STATUS_W-1:0]  r_res_status, n_res_status;
    logic [P_MAX_NODES-1:0] r_visited, n_visited;
    logic [P_MAX_NODES-1:0] r_len_vld, n_len_vld;
    logic                 r_len_rd_vld;

    logic                 r_out_valid;
    logic [NODE_W-1:0]    r_out_node;
    logic                 r_out_found;
    logic                 r_out_last;
    logic [STATUS_W-1:0]  r_out_status;
    logic                 out_free;
    logic                 out_load;
    logic [NODE_W-1:0]    out_node;
    logic                 out_found;
    logic                 out_last;
    logic [STATUS_W-1:0]  out_status;

    logic                 first_ok, second_ok, add_full;

    logic                 len_we, len_re;
    logic [NIW-1:0]       len_waddr, len_raddr;
    logic [LW-1:0]        len_wdata, len_rdata, len_q;
    logic                 adj_we, adj_re;
    logic [AW-1:0]        adj_waddr, adj_raddr;
    logic [NIW-1:0]       adj_wdata, adj_rdata;
    logic                 stk_we, stk_re;
    logic [NIW-1:0]       stk_waddr, stk_raddr;
    logic [SW-1:0]        stk_wdata, stk_rdata;

    // ---------------------------------------------------------------- stores
    gdfw_ram #(.P_WIDTH(LW), .P_DEPTH(P_MAX_NODES), .P_AW(NIW)) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (len_waddr),
        .i_wdata (len_wdata),
        .i_re    (len_re),
        .i_raddr (len_raddr),
        .o_rdata (len_rdata)
    );

    gdfw_ram #(.P_WIDTH(NIW), .P_DEPTH(P_MAX_NODES * P_MAX_DEGREE), .P_AW(AW)) u_adj_ram (
        .i_clk   (i_clk),
        .i_we    (adj_we),
        .i_waddr (adj_waddr),
        .i_wdata (adj_wdata),
        .i_re    (adj_re),
        .i_raddr (adj_raddr),
        .o_rdata (adj_rdata)
    );

    // stack entries below the top: {list position, node}; the top lives in r_cur/r_pos
    gdfw_ram #(.P_WIDTH(SW), .P_DEPTH(P_MAX_NODES), .P_AW(NIW)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    // a length never written reads as zero
    assign len_q = r_len_rd_vld ? len_rdata : '0;

    // ------------------------------------------------------- configuration
    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_clamped = CW'(1);
        end else if (32'(i_cfg_wdata) > 32'(P_MAX_NODES)) begin
            cfg_clamped = CW'(P_MAX_NODES);
        end else begin
            cfg_clamped = CW'(i_cfg_wdata);
        end
    end

    assign first_ok  = 32'(r_first) < 32'(r_node_count);
    assign second_ok = 32'(r_second) < 32'(r_node_count);

    // self-loop needs two free slots, otherwise each end needs one
    always_comb begin
        if (r_first == r_second) begin
            add_full = (32'(r_la) + 32'd2) > 32'(P_MAX_DEGREE);
        end else begin
            add_full = (32'(r_la) >= 32'(P_MAX_DEGREE)) ||
                       (32'(len_q) >= 32'(P_MAX_DEGREE));
        end
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    // ------------------------------------------------------------ sequencer
    always_comb begin
        n_state      = r_state;
        n_req        = r_req;
        n_first      = r_first;
        n_second     = r_second;
        n_value      = r_value;
        n_la         = r_la;
        n_lb         = r_lb;
        n_cur        = r_cur;
        n_pos        = r_pos;
        n_len        = r_len;
        n_sdepth     = r_sdepth;
        n_pend       = r_pend;
        n_qi         = r_qi;
        n_res_node   = r_res_node;
        n_res_found  = r_res_found;
        n_res_status = r_res_status;
        n_visited    = r_visited;
        n_len_vld    = r_len_vld;

        len_we    = 1'b0;
        len_waddr = '0;
        len_wdata = '0;
        len_re    = 1'b0;
        len_raddr = '0;
        adj_we    = 1'b0;
        adj_waddr = '0;
        adj_wdata = '0;
        adj_re    = 1'b0;
        adj_raddr = '0;
        stk_we    = 1'b0;
        stk_waddr = '0;
        stk_wdata = '0;
        stk_re    = 1'b0;
        stk_raddr = '0;

        out_load   = 1'b0;
        out_node   = '0;
        out_found  = 1'b0;
        out_last   = 1'b0;
        out_status = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_req    = i_s_axis_tuser;
                    n_first  = i_s_axis_tdata[3:0];
                    n_second = i_s_axis_tdata[7:4];
                    n_value  = i_s_axis_tdata[15:8];
                    n_state  = S_DECODE;
                end
            end

            S_DECODE: begin
                n_res_node   = '0;
                n_res_found  = 1'b0;
                n_res_status = ST_OK;
                case (r_req)
                    REQ_ADD: begin
                        if (!first_ok || !second_ok) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RES;
                        end else begin
                            len_re    = 1'b1;
                            len_raddr = NIW'(r_first);
                            n_state   = S_ADD_LB;
                        end
                    end
                    REQ_WALK: begin
                        if (!first_ok) begin
                            n_res_status = ST_RANGE;
                            n_state      = S_RES;
                        end else begin
                            // mark and hold the start node as the first result
                            n_visited[NIW'(r_first)] = 1'b1;
                            n_pend    = NIW'(r_first);
                            n_cur     = NIW'(r_first);
                            n_pos     = '0;
                            n_sdepth  = '0;
                            len_re    = 1'b1;
                            len_raddr = NIW'(r_first);
                            n_state   = S_W_LEN;
                        end
                    end
                    REQ_QUERY: begin
                        n_qi      = '0;
                        len_re    = 1'b1;
                        len_raddr = '0;
                        n_state   = S_Q_LENW;
                    end
                    default: begin
                        n_state = S_RES;
                    end
                endcase
            end

            S_ADD_LB: begin
                n_la      = len_q;
                len_re    = 1'b1;
                len_raddr = NIW'(r_second);
                n_state   = S_ADD_CHK;
            end

            S_ADD_CHK: begin
                if (add_full) begin
                    n_res_status = ST_FULL;
                    n_state      = S_RES;
                end else begin
                    adj_we    = 1'b1;
                    adj_waddr = f_adj_addr(NIW'(r_first), r_la);
                    adj_wdata = NIW'(r_second);
                    len_we    = 1'b1;
                    len_waddr = NIW'(r_first);
                    len_wdata = r_la + LW'(1);
                    n_len_vld[NIW'(r_first)] = 1'b1;
                    // self-loop: second append goes one slot further
                    n_lb      = (r_first == r_second) ? (r_la + LW'(1)) : len_q;
                    n_state   = S_ADD_W2;
                end
            end

            S_ADD_W2: begin
                adj_we    = 1'b1;
                adj_waddr = f_adj_addr(NIW'(r_second), r_lb);
                adj_wdata = NIW'(r_first);
                len_we    = 1'b1;
                len_waddr = NIW'(r_second);
                len_wdata = r_lb + LW'(1);
                n_len_vld[NIW'(r_second)] = 1'b1;
                n_state   = S_RES;
            end

            S_W_LEN: begin
                n_len   = len_q;
                n_state = S_W_STEP;
            end

            S_W_STEP: begin
                if (r_pos >= r_len) begin
                    if (r_sdepth == '0) begin
                        n_state = S_W_FIN;
                    end else begin
                        stk_re    = 1'b1;
                        stk_raddr = NIW'(r_sdepth - CW'(1));
                        n_state   = S_W_POP;
                    end
                end else begin
                    adj_re    = 1'b1;
                    adj_raddr = f_adj_addr(r_cur, r_pos);
                    n_pos     = r_pos + LW'(1);
                    n_state   = S_W_NB;
                end
            end

            S_W_POP: begin
                n_cur     = stk_rdata[NIW-1:0];
                n_pos     = stk_rdata[SW-1:NIW];
                n_sdepth  = r_sdepth - CW'(1);
                len_re    = 1'b1;
                len_raddr = stk_rdata[NIW-1:0];
                n_state   = S_W_LEN;
            end

            S_W_NB: begin
                if (r_visited[adj_rdata]) begin
                    n_state = S_W_STEP;
                end else if (out_free) begin
                    // release the held result; the new node becomes the held one
                    out_load   = 1'b1;
                    out_node   = NODE_W'(r_pend);
                    n_visited[adj_rdata] = 1'b1;
                    n_pend     = adj_rdata;
                    stk_we     = 1'b1;
                    stk_waddr  = NIW'(r_sdepth);
                    stk_wdata  = {r_pos, r_cur};
                    n_sdepth   = r_sdepth + CW'(1);
                    n_cur      = adj_rdata;
                    n_pos      = '0;
                    len_re     = 1'b1;
                    len_raddr  = adj_rdata;
                    n_state    = S_W_LEN;
                end
            end

            S_W_FIN: begin
                if (out_free) begin
                    out_load = 1'b1;
                    out_node = NODE_W'(r_pend);
                    out_last = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            S_Q_LENW: begin
                n_len   = len_q;
                n_pos   = '0;
                n_state = S_Q_STEP;
            end

            S_Q_STEP: begin
                if (r_pos >= r_len) begin
                    if ((32'(r_qi) + 32'd1) >= 32'(r_node_count)) begin
                        n_state = S_RES;
                    end else begin
                        n_qi      = r_qi + CW'(1);
                        len_re    = 1'b1;
                        len_raddr = NIW'(r_qi + CW'(1));
                        n_state   = S_Q_LENW;
                    end
                end else begin
                    adj_re    = 1'b1;
                    adj_raddr = f_adj_addr(NIW'(r_qi), r_pos);
                    n_pos     = r_pos + LW'(1);
                    n_state   = S_Q_CMP;
                end
            end

            S_Q_CMP: begin
                if (32'(r_value) == 32'(adj_rdata)) begin
                    n_res_node  = NODE_W'(r_qi);
                    n_res_found = 1'b1;
                    n_state     = S_RES;
                end else begin
                    n_state = S_Q_STEP;
                end
            end

            S_RES: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_node   = r_res_node;
                    out_found  = r_res_found;
                    out_last   = 1'b1;
                    out_status = r_res_status;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // -------------------------------------------------------- control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_node_count <= CW'((P_MAX_NODES < 16) ? P_MAX_NODES : 16);
            r_visited    <= '0;
            r_len_vld    <= '0;
            r_len_rd_vld <= 1'b0;
            r_sdepth     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_visited <= n_visited;
            r_len_vld <= n_len_vld;
            r_sdepth  <= n_sdepth;
            if (i_cfg_we) begin
                r_node_count <= cfg_clamped;
            end
            if (len_re) begin
                r_len_rd_vld <= r_len_vld[len_raddr];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------ payload state
    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_first      <= n_first;
        r_second     <= n_second;
        r_value      <= n_value;
        r_la         <= n_la;
        r_lb         <= n_lb;
        r_cur        <= n_cur;
        r_pos        <= n_pos;
        r_len        <= n_len;
        r_pend       <= n_pend;
        r_qi         <= n_qi;
        r_res_node   <= n_res_node;
        r_res_found  <= n_res_found;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_node   <= out_node;
            r_out_found  <= out_found;
            r_out_last   <= out_last;
            r_out_status <= out_status;
        end
    end

    // -------------------------------------------------------------- ports
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_status, r_out_found, r_out_node};
    assign o_m_axis_tlast  = r_out_last;

endmodule

@@ dv/tb_graph_depth_first_walk_unit.sv @@
`timescale 1ns / 100ps
// Self-checking bench for graph_depth_first_walk_unit: stream driver and monitor with
// a shadow graph that predicts every result. Depends on gdfw_pkg and the unit's RTL.
module tb_graph_depth_first_walk_unit;
    import gdfw_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;   // undefined request kind
    localparam int CFG_SETTLE  = 16;        // quiet cycles before a node_count write
    localparam int DRAIN_WAIT  = 400;       // longest walk, with margin
    localparam int HOLD_CYCLES = 600;       // long receiver hold-off
    localparam int LIMIT       = 2_000_000;

    typedef struct packed {
        logic [NODE_W-1:0]   node_id;
        logic                found;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_walk_result;

    typedef struct {
        bit                 is_cfg;
        logic [CFG_W-1:0]   cfg_value;
        logic [REQ_W-1:0]   kind;
        logic [NODE_W-1:0]  a;
        logic [NODE_W-1:0]  b;
        logic [VALUE_W-1:0] value;
    } t_graph_request;

    logic                 i_clk           = 1'b0;
    logic                 i_rst_n         = 1'b0;
    logic                 i_cfg_we        = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata     = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    // first_node[3:0], second_node[7:4], search_value[15:8]
    logic [S_TDATA_W-1:0] i_s_axis_tdata  = '0;
    // req_type[1:0]
    logic [REQ_W-1:0]     i_s_axis_tuser  = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    // node_id[3:0], found[4], status[6:5], zero pad[7]
    logic [M_TDATA_W-1:0] o_m_axis_tdata;
    logic                 o_m_axis_tlast;

    graph_depth_first_walk_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #2 i_clk = ~i_clk;

    // Shadow of the graph: adjacency lists, their lengths, persistent visited marks
    // and the node count currently in force.
    logic [NODE_W-1:0] shadow_adj [MAX_NODES][MAX_DEGREE];
    int                shadow_len [MAX_NODES];
    bit                shadow_seen[MAX_NODES];
    int                shadow_nodes = MAX_NODES;

    t_graph_request pending_requests[$];   // requests and node_count writes, in order
    t_walk_result   graph_results_due[$];  // predicted results not yet seen
    t_graph_request offered;               // request currently on the slave side
    int  requests_taken = 0;
    int  mismatches     = 0;
    int  cycles         = 0;
    int  send_gap       = 0;
    int  recv_gap       = 0;
    int  quiet_cycles   = 0;
    int  hold_left      = 0;
    int  holdoffs_done  = 0;
    bit  send_calm      = 1'b0;
    bit  recv_calm      = 1'b0;

    initial begin
        for (int n = 0; n < MAX_NODES; n++) begin
            shadow_len[n]  = 0;
            shadow_seen[n] = 1'b0;
        end
    end

    // Written value 0 acts as one node; anything above the maximum clamps to it.
    function automatic int clamp_nodes(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_NODES) return MAX_NODES;
        return v;
    endfunction

    // Draw a random idle gap; now and then swap into or out of a calm stretch where
    // no gaps are drawn at all.
    function automatic int pick_gap(inout bit calm);
        if ($urandom_range(0, 19) == 0) calm = ~calm;
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Mostly a node in use, sometimes any node so the range check gets exercised.
    function automatic logic [NODE_W-1:0] pick_node(int in_use);
        if ($urandom_range(0, 9) == 0) return NODE_W'($urandom_range(0, MAX_NODES - 1));
        return NODE_W'($urandom_range(0, in_use - 1));
    endfunction

    // Append to the tails of the request and prediction queues.
    function automatic void append_request(t_graph_request r);
        pending_requests = {pending_requests, r};
    endfunction

    function automatic void append_due(t_walk_result r);
        graph_results_due = {graph_results_due, r};
    endfunction

    function automatic void queue_request(logic [REQ_W-1:0] kind, logic [NODE_W-1:0] a,
                                          logic [NODE_W-1:0] b, logic [VALUE_W-1:0] value);
        t_graph_request r;
        r.is_cfg    = 1'b0;
        r.cfg_value = '0;
        r.kind      = kind;
        r.a         = a;
        r.b         = b;
        r.value     = value;
        append_request(r);
    endfunction

    function automatic void queue_config(logic [CFG_W-1:0] value);
        t_graph_request r;
        r.is_cfg    = 1'b1;
        r.cfg_value = value;
        r.kind      = REQ_ADD;
        r.a         = '0;
        r.b         = '0;
        r.value     = '0;
        append_request(r);
    endfunction

    // Apply one accepted request to the shadow graph and queue the results it yields.
    function automatic void run_graph_request(t_graph_request r);
        t_walk_result      res;
        t_walk_result      step_res;
        t_walk_result      walk_out[$];
        logic [NODE_W-1:0] stk_node[MAX_NODES];
        int                stk_pos[MAX_NODES];
        int                depth;
        int                pos;
        logic [NODE_W-1:0] cur;
        logic [NODE_W-1:0] nb;
        bit                hit;
        bit                no_room;
        res = '{node_id: '0, found: 1'b0, last: 1'b1, status: ST_OK};
        case (r.kind)
            REQ_ADD: begin
                // a self-loop takes two slots of the same list
                no_room = (r.a == r.b) ? (shadow_len[r.a] + 2 > MAX_DEGREE)
                                       : (shadow_len[r.a] >= MAX_DEGREE ||
                                          shadow_len[r.b] >= MAX_DEGREE);
                if (r.a >= shadow_nodes || r.b >= shadow_nodes) begin
                    res.status = ST_RANGE;
                end else if (no_room) begin
                    res.status = ST_FULL;
                end else begin
                    shadow_adj[r.a][shadow_len[r.a]] = r.b;
                    shadow_len[r.a]++;
                    shadow_adj[r.b][shadow_len[r.b]] = r.a;
                    shadow_len[r.b]++;
                end
                append_due(res);
            end
            REQ_WALK: begin
                if (r.a >= shadow_nodes) begin
                    res.status = ST_RANGE;
                    append_due(res);
                end else begin
                    // the start is emitted even when already visited
                    shadow_seen[r.a] = 1'b1;
                    step_res = '{node_id: r.a, found: 1'b0, last: 1'b0, status: ST_OK};
                    walk_out = {walk_out, step_res};
                    stk_node[0] = r.a;
                    stk_pos[0]  = 0;
                    depth       = 1;
                    while (depth > 0) begin
                        cur = stk_node[depth-1];
                        pos = stk_pos[depth-1];
                        if (pos >= shadow_len[cur]) begin
                            depth--;
                        end else begin
                            stk_pos[depth-1] = pos + 1;
                            nb = shadow_adj[cur][pos];
                            // stored edges are followed even past the current node count
                            if (!shadow_seen[nb] && walk_out.size() < 64) begin
                                shadow_seen[nb] = 1'b1;
                                step_res = '{node_id: nb, found: 1'b0, last: 1'b0,
                                             status: ST_OK};
                                walk_out = {walk_out, step_res};
                                if (depth < MAX_NODES) begin
                                    stk_node[depth] = nb;
                                    stk_pos[depth]  = 0;
                                    depth++;
                                end
                            end
                        end
                    end
                    walk_out[walk_out.size()-1].last = 1'b1;
                    foreach (walk_out[k]) append_due(walk_out[k]);
                end
            end
            REQ_QUERY: begin
                hit = 1'b0;
                for (int i = 0; i < shadow_nodes && !hit; i++) begin
                    for (int j = 0; j < shadow_len[i] && !hit; j++) begin
                        if (shadow_adj[i][j] == r.value) begin
                            res.node_id = NODE_W'(i);
                            res.found   = 1'b1;
                            hit         = 1'b1;
                        end
                    end
                end
                append_due(res);
            end
            default: append_due(res);
        endcase
    endfunction

    // Request driver: offer queued requests with random gaps; issue node_count
    // writes only once every predicted result has come back and the unit is quiet.
    always @(posedge i_clk) begin : request_driver
        logic           offer;
        logic           cfg_pulse;
        t_graph_request head;
        offer     = i_s_axis_tvalid;
        cfg_pulse = 1'b0;
        if (!i_rst_n) begin
            offer = 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                run_graph_request(offered);
                requests_taken++;
                offer    = 1'b0;
                send_gap = pick_gap(send_calm);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_requests.size() > 0) begin
                    head = pending_requests[0];
                    if (!head.is_cfg) begin
                        void'(pending_requests.pop_front());
                        offered = head;
                        offer   = 1'b1;
                        i_s_axis_tdata <= {head.value, head.b, head.a};
                        i_s_axis_tuser <= head.kind;
                    end else if (graph_results_due.size() != 0) begin
                        quiet_cycles = 0;
                    end else if (quiet_cycles < CFG_SETTLE) begin
                        quiet_cycles++;
                    end else begin
                        // unit idle: write node_count and mirror it
                        void'(pending_requests.pop_front());
                        quiet_cycles = 0;
                        cfg_pulse    = 1'b1;
                        i_cfg_wdata  <= head.cfg_value;
                        shadow_nodes = clamp_nodes(head.cfg_value);
                    end
                end
            end
        end
        i_s_axis_tvalid <= offer;
        i_cfg_we        <= cfg_pulse;
    end

    // Receiver ready: random stalls after each transaction, plus two long hold-offs
    // so the output register fills and the request side backs up.
    always @(posedge i_clk) begin : result_ready
        logic take;
        take = i_m_axis_tready;
        if (!i_rst_n) begin
            take = 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            take = (hold_left == 0);
        end else if (holdoffs_done < 2 && requests_taken >= 30 + 190 * holdoffs_done) begin
            holdoffs_done++;
            hold_left = HOLD_CYCLES;
            take      = 1'b0;
        end else if (i_m_axis_tready && o_m_axis_tvalid) begin
            recv_gap = pick_gap(recv_calm);
            take     = (recv_gap == 0);
        end else if (recv_gap > 0) begin
            recv_gap--;
            take = (recv_gap == 0);
        end else begin
            take = 1'b1;
        end
        i_m_axis_tready <= take;
    end

    // Result monitor: match each transaction against the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_walk_result got;
        t_walk_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = '{node_id: o_m_axis_tdata[3:0], found: o_m_axis_tdata[4],
                    last: o_m_axis_tlast, status: o_m_axis_tdata[6:5]};
            if (graph_results_due.size() == 0) begin
                $error("result with nothing outstanding: tdata %h tlast %b",
                       o_m_axis_tdata, o_m_axis_tlast);
                mismatches++;
            end else begin
                want = graph_results_due.pop_front();
                if (got.node_id !== want.node_id) begin
                    $error("node_id: expected %0d, got %0d", want.node_id, got.node_id);
                    mismatches++;
                end
                if (got.found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    mismatches++;
                end
                if (got.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    mismatches++;
                end
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: give up well beyond the slowest legal run.
    always @(posedge i_clk) begin : watchdog
        cycles++;
        if (cycles >= LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin : stimulus
        int               nodes_now;
        int               pick;
        logic [CFG_W-1:0] cfg;
        // Directed part. At reset every list is empty: the query finds nothing.
        queue_request(REQ_QUERY, 4'd0, 4'd0, 8'hFF);
        // Single node: self-loop, out-of-range edge and walk, walk over own loop.
        queue_config(5'd0);
        queue_request(REQ_ADD,   4'd0, 4'd0, 8'h00);
        queue_request(REQ_ADD,   4'd0, 4'd1, 8'h00);
        queue_request(REQ_WALK,  4'd1, 4'd0, 8'h00);
        queue_request(REQ_WALK,  4'd0, 4'd0, 8'h00);
        queue_request(REQ_QUERY, 4'd0, 4'd0, 8'h00);
        queue_request(REQ_UNUSED, 4'hF, 4'hF, 8'hFF);
        // Above the maximum: clamps to all nodes. Build a ring with a branch.
        queue_config(5'd31);
        queue_request(REQ_ADD, 4'd15, 4'd14, 8'h00);
        queue_request(REQ_ADD, 4'd14, 4'd13, 8'h00);
        queue_request(REQ_ADD, 4'd13, 4'd12, 8'h00);
        queue_request(REQ_ADD, 4'd12, 4'd15, 8'h00);
        queue_request(REQ_ADD, 4'd14, 4'd2,  8'h00);
        // Fill node 5 with self-loops, then hit the full list both ways.
        repeat (5) queue_request(REQ_ADD, 4'd5, 4'd5, 8'h00);
        queue_request(REQ_ADD, 4'd5, 4'd6, 8'h00);
        queue_request(REQ_ADD, 4'd3, 4'd9, 8'h00);
        // Deep walk, then a walk from a start already visited.
        queue_request(REQ_WALK,  4'd15, 4'd0, 8'h00);
        queue_request(REQ_WALK,  4'd14, 4'd0, 8'h00);
        queue_request(REQ_QUERY, 4'd0,  4'd0, 8'd12);
        // Shrink: the walk still follows the edge to node 9, the query skips it.
        queue_config(5'd4);
        queue_request(REQ_WALK,  4'd3, 4'd0, 8'h00);
        queue_request(REQ_QUERY, 4'd0, 4'd0, 8'd9);
        queue_request(REQ_QUERY, 4'd0, 4'd0, 8'd3);

        // Random part: six phases, each under its own node count.
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       cfg = 5'd16;
                2:       cfg = 5'd10;
                3:       cfg = 5'd2;
                5:       cfg = 5'd16;
                default: cfg = CFG_W'($urandom_range(0, 31));
            endcase
            queue_config(cfg);
            nodes_now = clamp_nodes(cfg);
            for (int k = 0; k < 58; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    queue_request(REQ_ADD, pick_node(nodes_now), pick_node(nodes_now),
                                  VALUE_W'($urandom));
                end else if (pick < 62) begin
                    queue_request(REQ_WALK, pick_node(nodes_now), NODE_W'($urandom),
                                  VALUE_W'($urandom));
                end else if (pick < 95) begin
                    queue_request(REQ_QUERY, NODE_W'($urandom), NODE_W'($urandom),
                                  ($urandom_range(0, 3) == 0) ? VALUE_W'($urandom_range(0, 255))
                                                              : VALUE_W'($urandom_range(0, 15)));
                end else begin
                    queue_request(REQ_UNUSED, NODE_W'($urandom), NODE_W'($urandom),
                                  VALUE_W'($urandom));
                end
            end
        end

        // Hold reset while the clock runs, then release it for good.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: everything offered, accepted and answered, then let the unit settle.
        while (pending_requests.size() != 0 || i_s_axis_tvalid ||
               graph_results_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
